/* rtl/lrau_pkg.sv */
// shared types, constants and helpers of the low-rank adapter update block
package lrau_pkg;

    localparam int MaxLen   = 64;
    localparam int MaxRank  = 16;
    localparam int IdxW     = $clog2(MaxLen);
    localparam int RIdxW    = $clog2(MaxRank);
    localparam int LenW     = 7;
    localparam int RankW    = 5;
    localparam int CntW     = $clog2(MaxRank + 1);
    localparam int AddrW    = IdxW + RIdxW;
    localparam int WordW    = 16;
    localparam int SumW     = 40;
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);

    // command codes on the input tuser
    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_ELEM = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_VEC_LEN    = 2'd0,
        REG_RANK       = 2'd1,
        REG_ALPHA      = 2'd2,
        REG_USER_SCALE = 2'd3
    } t_reg;

    // work kinds passed from front to back
    typedef enum logic [1:0] {
        OP_WR_A,
        OP_WR_B,
        OP_ELEM
    } t_op;

    typedef struct packed {
        logic [LenW-1:0]  vec_len;
        logic [RankW-1:0] rank;
        logic [15:0]      alpha;
        logic [15:0]      user_scale;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [AddrW-1:0] addr;
        logic [WordW-1:0] data;
        logic [WordW-1:0] base;
        logic             last;
    } t_qent;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_DOT,
        ST_SCALE_D,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_NORM,
        ST_DIV,
        ST_RESULT
    } t_state;

    // vector length clamped to 1..MaxLen
    function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] v);
        logic [LenW-1:0] r;
        if (v == '0)
            r = LenW'(1);
        else if (v > LenW'(MaxLen))
            r = LenW'(MaxLen);
        else
            r = v;
        return r;
    endfunction

    // rank clamped to 1..MaxRank
    function automatic logic [RankW-1:0] eff_rank(input logic [RankW-1:0] v);
        logic [RankW-1:0] r;
        if (v == '0)
            r = RankW'(1);
        else if (v > RankW'(MaxRank))
            r = RankW'(MaxRank);
        else
            r = v;
        return r;
    endfunction

endpackage

/* rtl/lrau_fifo.sv */
// short request queue between the front and the back
module lrau_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lrau_pkg::t_qent i_push_ent,
    input  logic            i_pop,
    output lrau_pkg::t_qent o_head,
    output logic            o_empty,
    output logic            o_full
);

    lrau_pkg::t_qent                 r_mem [lrau_pkg::QDepth];
    logic [lrau_pkg::QPtrW-1:0]      r_wp;
    logic [lrau_pkg::QPtrW-1:0]      r_rp;
    logic [lrau_pkg::QPtrW:0]        r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (lrau_pkg::QPtrW+1)'(lrau_pkg::QDepth));
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_ent;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* rtl/lrau_front.sv */
// request intake: configuration registers, command decode and element counting
module lrau_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [63:0]     s_axis_tdata,
    input  logic [1:0]      s_axis_tuser,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    output lrau_pkg::t_cfg  o_cfg,
    output logic            o_push,
    output lrau_pkg::t_qent o_push_ent,
    input  logic            i_full
);

    lrau_pkg::t_cfg                r_cfg;
    logic [lrau_pkg::LenW-1:0]     r_count;
    logic [lrau_pkg::LenW-1:0]     n_count;
    logic                          accept;
    lrau_pkg::t_cmd                cmd;
    logic [5:0]                    row;
    logic [5:0]                    col;
    logic [15:0]                   weight;
    logic [15:0]                   x_val;
    logic [15:0]                   base_val;
    logic [lrau_pkg::IdxW-1:0]     elem_n;
    logic                          elem_last;
    logic                          ent_ok;

    assign o_cfg_ready   = 1'b1;
    assign o_cfg         = r_cfg;
    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // field unpack
    assign cmd      = lrau_pkg::t_cmd'(s_axis_tuser);
    assign row      = s_axis_tdata[5:0];
    assign col      = s_axis_tdata[11:6];
    assign weight   = s_axis_tdata[27:12];
    assign x_val    = s_axis_tdata[43:28];
    assign base_val = s_axis_tdata[59:44];

    // element position, held at the last slot if the count runs over
    always_comb begin
        if (r_count >= lrau_pkg::LenW'(lrau_pkg::MaxLen - 1))
            elem_n = lrau_pkg::IdxW'(lrau_pkg::MaxLen - 1);
        else
            elem_n = r_count[lrau_pkg::IdxW-1:0];
        elem_last = (lrau_pkg::LenW'(elem_n) + lrau_pkg::LenW'(1))
                    >= lrau_pkg::eff_len(r_cfg.vec_len);
    end

    // classify the request into a queue entry
    always_comb begin
        o_push_ent.op   = lrau_pkg::OP_ELEM;
        o_push_ent.addr = lrau_pkg::AddrW'(elem_n);
        o_push_ent.data = x_val;
        o_push_ent.base = base_val;
        o_push_ent.last = elem_last;
        ent_ok          = 1'b0;
        n_count         = r_count;
        unique case (cmd)
            lrau_pkg::CMD_WR_A: begin
                o_push_ent.op   = lrau_pkg::OP_WR_A;
                o_push_ent.addr = {row[lrau_pkg::IdxW-1:0], col[lrau_pkg::RIdxW-1:0]};
                o_push_ent.data = weight;
                ent_ok          = (6'(col) < 6'(lrau_pkg::MaxRank));
            end
            lrau_pkg::CMD_WR_B: begin
                o_push_ent.op   = lrau_pkg::OP_WR_B;
                o_push_ent.addr = {row[lrau_pkg::RIdxW-1:0], col[lrau_pkg::IdxW-1:0]};
                o_push_ent.data = weight;
                ent_ok          = (6'(row) < 6'(lrau_pkg::MaxRank));
            end
            lrau_pkg::CMD_ELEM: begin
                ent_ok  = 1'b1;
                n_count = elem_last ? '0 : lrau_pkg::LenW'(elem_n) + lrau_pkg::LenW'(1);
            end
            lrau_pkg::CMD_NONE: begin
                ent_ok = 1'b0;
            end
            default: begin
                ent_ok = 1'b0;
            end
        endcase
    end

    assign o_push = accept && ent_ok;

    // element counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vec_len    <= lrau_pkg::LenW'(64);
            r_cfg.rank       <= lrau_pkg::RankW'(16);
            r_cfg.alpha      <= 16'd4096;
            r_cfg.user_scale <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (lrau_pkg::t_reg'(i_cfg_index))
                lrau_pkg::REG_VEC_LEN:    r_cfg.vec_len    <= i_cfg_data[lrau_pkg::LenW-1:0];
                lrau_pkg::REG_RANK:       r_cfg.rank       <= i_cfg_data[lrau_pkg::RankW-1:0];
                lrau_pkg::REG_ALPHA:      r_cfg.alpha      <= i_cfg_data;
                lrau_pkg::REG_USER_SCALE: r_cfg.user_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/lrau_back.sv */
// execution engine: weight stores, shared multiply-accumulate, scaling, divider, output register
module lrau_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lrau_pkg::t_cfg  i_cfg,
    input  lrau_pkg::t_qent i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,
    output logic            m_axis_tlast,
    output logic            m_axis_tuser
);

    localparam int DW = 34;   // rounded dot product
    localparam int PW = 51;   // partial product
    localparam int SW = 67;   // full scaled product
    localparam int QW = 23;   // divider width

    lrau_pkg::t_state r_state;
    lrau_pkg::t_state n_state;

    // stores
    logic signed [15:0] down_mem [1 << lrau_pkg::AddrW];
    logic signed [15:0] up_mem   [1 << lrau_pkg::AddrW];
    logic signed [15:0] base_mem [lrau_pkg::MaxLen];
    logic signed [15:0] r_a_rd;
    logic signed [15:0] r_b_rd;
    logic signed [15:0] r_base_rd;

    logic signed [lrau_pkg::SumW-1:0] r_sums [lrau_pkg::MaxRank];

    logic [lrau_pkg::CntW-1:0]   r_cnt;
    logic                        r_rdv;
    logic [lrau_pkg::RIdxW-1:0]  r_ridx;
    logic signed [15:0]          r_x;
    logic [lrau_pkg::IdxW-1:0]   r_n;
    logic                        r_last;
    logic [lrau_pkg::IdxW-1:0]   r_i;
    logic signed [55:0]          r_prod;
    logic                        r_pv;
    logic signed [63:0]          r_u;
    logic signed [DW-1:0]        r_d;
    logic [31:0]                 r_scale;
    logic signed [PW-1:0]        r_pp;
    logic signed [SW-1:0]        r_p;
    logic                        r_neg;
    logic [QW-1:0]               r_dq;
    logic [lrau_pkg::RankW-1:0]  r_rem;
    logic [4:0]                  r_dcnt;
    logic                        r_out_valid;
    logic [15:0]                 r_out_value;
    logic [lrau_pkg::IdxW-1:0]   r_out_index;
    logic                        r_out_last;
    logic                        r_out_sat;

    logic [lrau_pkg::RankW-1:0]  rk;
    logic [lrau_pkg::LenW-1:0]   len;
    logic                        a_we;
    logic                        b_we;
    logic                        x_we;
    logic [lrau_pkg::AddrW-1:0]  a_ra;
    logic [lrau_pkg::AddrW-1:0]  b_ra;
    logic                        out_free;
    logic                        elem_done;
    logic                        vec_done;
    logic signed [31:0]          mac_p;
    logic signed [63:0]          u_rnd;
    logic signed [SW-1:0]        p_rnd;
    logic signed [SW-17:0]       m_full;
    logic signed [21:0]          m_cl;
    logic [QW-1:0]               div_a;
    logic [lrau_pkg::RankW:0]    rem_sh;
    logic [lrau_pkg::RankW:0]    rem_sub;
    logic                        qbit;
    logic signed [QW:0]          q_val;
    logic signed [QW+1:0]        v_sum;
    logic [15:0]                 v_out;
    logic                        v_sat;

    assign rk  = lrau_pkg::eff_rank(i_cfg.rank);
    assign len = lrau_pkg::eff_len(i_cfg.vec_len);

    assign o_pop = (r_state == lrau_pkg::ST_IDLE) && !i_empty;
    assign a_we  = o_pop && (i_head.op == lrau_pkg::OP_WR_A);
    assign b_we  = o_pop && (i_head.op == lrau_pkg::OP_WR_B);
    assign x_we  = o_pop && (i_head.op == lrau_pkg::OP_ELEM);
    assign a_ra  = {r_n, r_cnt[lrau_pkg::RIdxW-1:0]};
    assign b_ra  = {r_cnt[lrau_pkg::RIdxW-1:0], r_i};

    assign out_free  = !r_out_valid || m_axis_tready;
    assign elem_done = (r_cnt == lrau_pkg::CntW'(rk)) && !r_rdv && !r_pv;
    assign vec_done  = (lrau_pkg::LenW'(r_i) + lrau_pkg::LenW'(1)) == len;

    // down-projection store
    always_ff @(posedge i_clk) begin
        if (a_we) down_mem[i_head.addr] <= i_head.data;
        r_a_rd <= down_mem[a_ra];
    end

    // up-projection store
    always_ff @(posedge i_clk) begin
        if (b_we) up_mem[i_head.addr] <= i_head.data;
        r_b_rd <= up_mem[b_ra];
    end

    // base value store
    always_ff @(posedge i_clk) begin
        if (x_we) base_mem[i_head.addr[lrau_pkg::IdxW-1:0]] <= i_head.base;
        r_base_rd <= base_mem[r_i];
    end

    // arithmetic helpers
    always_comb begin
        mac_p  = r_x * r_a_rd;
        u_rnd  = r_u + 64'sd536870912;
        p_rnd  = r_p + SW'(signed'({1'b0, rk, 15'd0}));
        m_full = p_rnd[SW-1:16];
        if (m_full > (SW-16)'(signed'(22'sh1fffff)))
            m_cl = 22'sh1fffff;
        else if (m_full < (SW-16)'(signed'(22'sh200000)))
            m_cl = 22'sh200000;
        else
            m_cl = m_full[21:0];
        if (m_cl[21])
            div_a = QW'(-(QW'(m_cl))) + QW'(rk) - QW'(1);
        else
            div_a = QW'(m_cl);
        rem_sh  = {r_rem, r_dq[QW-1]};
        rem_sub = rem_sh - {1'b0, rk};
        qbit    = (rem_sh >= {1'b0, rk});
        q_val   = r_neg ? -(signed'({1'b0, r_dq})) : signed'({1'b0, r_dq});
        v_sum   = (QW+2)'(r_base_rd) + (QW+2)'(q_val);
        if (v_sum > (QW+2)'(32767)) begin
            v_out = 16'h7fff;
            v_sat = 1'b1;
        end else if (v_sum < -(QW+2)'(32768)) begin
            v_out = 16'h8000;
            v_sat = 1'b1;
        end else begin
            v_out = v_sum[15:0];
            v_sat = 1'b0;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrau_pkg::ST_IDLE: begin
                if (x_we) n_state = lrau_pkg::ST_ACC;
            end
            lrau_pkg::ST_ACC: begin
                if (r_cnt == lrau_pkg::CntW'(lrau_pkg::MaxRank))
                    n_state = r_last ? lrau_pkg::ST_DOT : lrau_pkg::ST_IDLE;
            end
            lrau_pkg::ST_DOT: begin
                if (elem_done) n_state = lrau_pkg::ST_SCALE_D;
            end
            lrau_pkg::ST_SCALE_D:  n_state = lrau_pkg::ST_SCALE_LO;
            lrau_pkg::ST_SCALE_LO: n_state = lrau_pkg::ST_SCALE_HI;
            lrau_pkg::ST_SCALE_HI: n_state = lrau_pkg::ST_NORM;
            lrau_pkg::ST_NORM:     n_state = lrau_pkg::ST_DIV;
            lrau_pkg::ST_DIV: begin
                if (r_dcnt == 5'(QW - 1)) n_state = lrau_pkg::ST_RESULT;
            end
            lrau_pkg::ST_RESULT: begin
                if (out_free)
                    n_state = vec_done ? lrau_pkg::ST_IDLE : lrau_pkg::ST_DOT;
            end
            default: n_state = lrau_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // rank sums: accumulate during intake, cleared after each vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lrau_pkg::MaxRank; k++) r_sums[k] <= '0;
        end else if (r_state == lrau_pkg::ST_ACC && r_rdv) begin
            r_sums[r_ridx] <= r_sums[r_ridx] + lrau_pkg::SumW'(mac_p);
        end else if (r_state == lrau_pkg::ST_RESULT && out_free && vec_done) begin
            for (int k = 0; k < lrau_pkg::MaxRank; k++) r_sums[k] <= '0;
        end
    end

    // sequencer control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rdv  <= 1'b0;
            r_pv   <= 1'b0;
            r_i    <= '0;
            r_dcnt <= '0;
        end else begin
            unique case (r_state)
                lrau_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                    r_rdv <= 1'b0;
                    r_pv  <= 1'b0;
                    r_i   <= '0;
                end
                lrau_pkg::ST_ACC: begin
                    if (r_cnt < lrau_pkg::CntW'(lrau_pkg::MaxRank)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_rdv <= 1'b1;
                    end else begin
                        r_cnt <= '0;
                        r_rdv <= 1'b0;
                    end
                end
                lrau_pkg::ST_DOT: begin
                    if (r_cnt < lrau_pkg::CntW'(rk)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                    end
                    r_pv <= r_rdv;
                end
                lrau_pkg::ST_NORM: begin
                    r_dcnt <= '0;
                end
                lrau_pkg::ST_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                lrau_pkg::ST_RESULT: begin
                    if (out_free) begin
                        r_cnt <= '0;
                        r_rdv <= 1'b0;
                        r_pv  <= 1'b0;
                        r_i   <= vec_done ? '0 : r_i + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ridx <= r_cnt[lrau_pkg::RIdxW-1:0];
        unique case (r_state)
            lrau_pkg::ST_IDLE: begin
                r_x    <= i_head.data;
                r_n    <= i_head.addr[lrau_pkg::IdxW-1:0];
                r_last <= i_head.last;
                r_u    <= '0;
            end
            lrau_pkg::ST_DOT: begin
                if (r_rdv) r_prod <= r_sums[r_ridx] * r_b_rd;
                if (r_pv)  r_u    <= r_u + 64'(r_prod);
            end
            lrau_pkg::ST_SCALE_D: begin
                r_d     <= u_rnd[63:30];
                r_scale <= i_cfg.alpha * i_cfg.user_scale;
            end
            lrau_pkg::ST_SCALE_LO: begin
                r_pp <= r_d * signed'({1'b0, r_scale[15:0]});
            end
            lrau_pkg::ST_SCALE_HI: begin
                r_p <= (SW'(r_d * signed'({1'b0, r_scale[31:16]})) <<< 16) + SW'(r_pp);
            end
            lrau_pkg::ST_NORM: begin
                r_dq  <= div_a;
                r_rem <= '0;
                r_neg <= m_cl[21];
            end
            lrau_pkg::ST_DIV: begin
                r_dq  <= {r_dq[QW-2:0], qbit};
                r_rem <= qbit ? rem_sub[lrau_pkg::RankW-1:0] : rem_sh[lrau_pkg::RankW-1:0];
            end
            lrau_pkg::ST_RESULT: begin
                if (out_free) r_u <= '0;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lrau_pkg::ST_RESULT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lrau_pkg::ST_RESULT && out_free) begin
            r_out_value <= v_out;
            r_out_index <= r_i;
            r_out_last  <= vec_done;
            r_out_sat   <= v_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_index, r_out_value};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_sat;

endmodule

/* rtl/low_rank_adapter_update_top.sv */
// top level of the low-rank adapter update block
//
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       tuser: cmd; tdata: row, col, weight, x, base
// m_axis    out        m_axis_tvalid/tready       tdata: out_value, out_index; tlast; tuser: sat
// cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// a weight write leaves the queue while the back end is idle; a vector element passes
// all 16 rank sums through the single shared accumulate multiplier in the back end
// the final element then adds per output: rank products through a second multiplier,
// four scaling steps and a 23-step serial divider by rank
// reset is synchronous and active low; no store is cleared, rank sums clear at once
// the four-entry queue lets the front keep taking requests while the back end works;
// the output register holds a result while m_axis_tready is low and the back end waits
module low_rank_adapter_update_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // row[5:0], col[11:6], weight[27:12], x[43:28], base[59:44]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_value[15:0], out_index[21:16]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // saturated
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    lrau_pkg::t_cfg  cfg;
    lrau_pkg::t_qent push_ent;
    lrau_pkg::t_qent head;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;

    // request intake
    lrau_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg),
        .o_push        (push),
        .o_push_ent    (push_ent),
        .i_full        (q_full)
    );

    // queue
    lrau_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    // execution
    lrau_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/lrau_checker.sv */
// port-level checker for the low-rank adapter update block and its bind
module lrau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    logic [lrau_pkg::LenW-1:0] r_len;
    logic [lrau_pkg::IdxW-1:0] r_exp;
    logic                      out_acc;
    logic [lrau_pkg::IdxW-1:0] out_idx;
    logic [lrau_pkg::IdxW-1:0] last_idx;

    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_idx  = m_axis_tdata[21:16];
    assign last_idx = lrau_pkg::IdxW'(lrau_pkg::eff_len(r_len) - lrau_pkg::LenW'(1));

    // shadow of the vector length and the expected index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= lrau_pkg::LenW'(64);
            r_exp <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready
                && lrau_pkg::t_reg'(i_cfg_index) == lrau_pkg::REG_VEC_LEN)
                r_len <= i_cfg_data[lrau_pkg::LenW-1:0];
            if (out_acc)
                r_exp <= m_axis_tlast ? '0 : out_idx + 1'b1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // results come in index order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> out_idx == r_exp)
        else $error("result index out of order");

    // last result sits at the end of the vector
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> m_axis_tlast == (out_idx == last_idx))
        else $error("last flag misplaced");

endmodule

bind low_rank_adapter_update_top lrau_checker u_lrau_checker (.*);

/* test/lrau_checker.sv */
// stream monitor, predictor and result comparator for the low-rank adapter update block
`timescale 1ns / 1ps

module lrau_scoreboard
    import lrau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [15:0] value;
        logic [5:0]  index;
        logic        last;
        logic        sat;
    } t_elem_result;

    // shadow copy of the block state
    logic signed [15:0] down_w [MaxLen*MaxRank];
    logic signed [15:0] up_w   [MaxRank*MaxLen];
    logic signed [15:0] x_vals [MaxLen];
    logic signed [15:0] base_vals [MaxLen];
    logic signed [39:0] proj_sum [MaxRank];
    int                 taken;
    logic [6:0]         len_reg;
    logic [4:0]         rank_reg;
    logic [15:0]        alpha_reg;
    logic [15:0]        scale_reg;

    t_elem_result results_due[$];
    int           fails = 0;

    assign o_fail_count = fails;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fails++;
    endtask

    // floor division for a positive divisor
    function automatic longint floor_quot(input longint n, input longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    // one accepted element: accumulate x*A, and on the closing element queue the outputs
    task automatic take_element(input logic signed [15:0] xv, input logic signed [15:0] bv);
        int           n;
        int           len;
        int           rk;
        longint       prod;
        longint       u;
        longint       d;
        longint       q;
        longint       v;
        longint       scale;
        t_elem_result res;
        n = (taken >= MaxLen) ? MaxLen - 1 : taken;
        x_vals[n] = xv;
        base_vals[n] = bv;
        for (int r = 0; r < MaxRank; r++) begin
            prod = longint'(xv) * longint'(down_w[n*MaxRank + r]);
            proj_sum[r] = proj_sum[r] + prod[39:0];
        end
        taken = n + 1;
        len = (len_reg == 0) ? 1 : (len_reg > MaxLen) ? MaxLen : int'(len_reg);
        if (taken < len)
            return;
        rk = (rank_reg == 0) ? 1 : (rank_reg > MaxRank) ? MaxRank : int'(rank_reg);
        scale = longint'(alpha_reg) * longint'(scale_reg);
        for (int i = 0; i < len; i++) begin
            u = 0;
            for (int r = 0; r < rk; r++)
                u += longint'(proj_sum[r]) * longint'(up_w[r*MaxLen + i]);
            d = floor_quot(u + (64'sd1 <<< 29), 64'sd1 <<< 30);
            q = floor_quot(d * scale + longint'(rk) * 32768, longint'(rk) * 65536);
            v = longint'(base_vals[i]) + q;
            res.sat = 1'b0;
            if (v > 32767) begin
                v = 32767;
                res.sat = 1'b1;
            end
            if (v < -32768) begin
                v = -32768;
                res.sat = 1'b1;
            end
            res.value = v[15:0];
            res.index = 6'(i);
            res.last = (i + 1 == len);
            results_due.insert(results_due.size(), res);
        end
        for (int r = 0; r < MaxRank; r++)
            proj_sum[r] = '0;
        taken = 0;
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        t_elem_result want;
        logic [5:0]   row;
        logic [5:0]   col;
        if (!i_rst_n) begin
            for (int r = 0; r < MaxRank; r++)
                proj_sum[r] = '0;
            taken = 0;
            len_reg = 7'd64;
            rank_reg = 5'd16;
            alpha_reg = 16'd4096;
            scale_reg = 16'd256;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_VEC_LEN:    len_reg = i_cfg_data[6:0];
                    REG_RANK:       rank_reg = i_cfg_data[4:0];
                    REG_ALPHA:      alpha_reg = i_cfg_data;
                    REG_USER_SCALE: scale_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                row = i_s_tdata[5:0];
                col = i_s_tdata[11:6];
                case (t_cmd'(i_s_tuser))
                    CMD_WR_A:
                        if (col < MaxRank)
                            down_w[row*MaxRank + col] = i_s_tdata[27:12];
                    CMD_WR_B:
                        if (row < MaxRank)
                            up_w[row*MaxLen + col] = i_s_tdata[27:12];
                    CMD_ELEM:
                        take_element(i_s_tdata[43:28], i_s_tdata[59:44]);
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    report($sformatf("unexpected output index %0d", i_m_tdata[21:16]));
                end else begin
                    want = results_due.pop_front();
                    if (i_m_tdata[15:0] !== want.value)
                        report($sformatf("value %h, want %h at index %0d",
                                         i_m_tdata[15:0], want.value, want.index));
                    if (i_m_tdata[21:16] !== want.index)
                        report($sformatf("index %0d, want %0d", i_m_tdata[21:16], want.index));
                    if (i_m_tlast !== want.last)
                        report($sformatf("last %b, want %b at index %0d",
                                         i_m_tlast, want.last, want.index));
                    if (i_m_tuser !== want.sat)
                        report($sformatf("saturated %b, want %b at index %0d",
                                         i_m_tuser, want.sat, want.index));
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

/* test/tb_top.sv */
// stimulus and verdict for the low-rank adapter update block
`timescale 1ns / 1ps

module tb_top;
    import lrau_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          sink_cycle = 0;
    int          sink_mode = 0;

    low_rank_adapter_update_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    lrau_scoreboard u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast), .i_m_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    // output stalls: always ready, coin flip, or mostly stalled, the mode picked at random
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 128 == 0)
            sink_mode <= $urandom_range(0, 2);
        case (sink_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // random word, often one of the extremes
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one request on the input stream, with bursts and gaps
    task automatic push_request(input t_cmd cmd, input logic [5:0] row, input logic [5:0] col,
                                input logic [15:0] w, input logic [15:0] x,
                                input logic [15:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, b, x, w, col, row};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic push_element(input logic [15:0] x, input logic [15:0] b);
        push_request(CMD_ELEM, 6'($urandom), 6'($urandom), rand_word(), x, b);
    endtask

    // let every expected output drain plus time for requests that produce none
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] len, input logic [15:0] rk,
                            input logic [15:0] al, input logic [15:0] us);
        write_reg(REG_VEC_LEN, len);
        write_reg(REG_RANK, rk);
        write_reg(REG_ALPHA, al);
        write_reg(REG_USER_SCALE, us);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(16, 1024));
        endcase
    endfunction

    initial begin
        int   items;
        int   len;
        int   big_runs;
        logic [15:0] len_val;
        items = 0;
        big_runs = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both matrices so no entry is read before written
        for (int r = 0; r < MaxLen; r++)
            for (int c = 0; c < MaxRank; c++)
                push_request(CMD_WR_A, 6'(r), 6'(c), rand_word(), rand_word(), rand_word());
        for (int r = 0; r < MaxRank; r++)
            for (int c = 0; c < MaxLen; c++)
                push_request(CMD_WR_B, 6'(r), 6'(c), rand_word(), rand_word(), rand_word());
        wait_idle();

        // full gain, rank one, extreme elements
        set_regs(16'd2, 16'd1, 16'hffff, 16'hffff);
        push_element(16'h7fff, 16'h7fff);
        push_element(16'h8000, 16'h8000);
        wait_idle();

        // zero gain passes the base; length below its range, rank above and below its range
        set_regs(16'd0, 16'd31, 16'd0, 16'd256);
        push_element(16'h8000, 16'h7fff);
        wait_idle();
        write_reg(REG_RANK, 16'd0);
        write_reg(REG_ALPHA, 16'd256);
        push_element(16'h7fff, 16'h8000);

        // weight extremes, ignored out-of-range writes, unknown command
        push_request(CMD_WR_A, 6'd63, 6'd15, 16'h7fff, 16'hffff, 16'hffff);
        push_request(CMD_WR_A, 6'd5, 6'd40, 16'h8000, 16'h0000, 16'h0000);
        push_request(CMD_WR_B, 6'd20, 6'd3, 16'h1234, 16'hffff, 16'h0000);
        push_request(CMD_WR_B, 6'd15, 6'd63, 16'h8000, 16'h0000, 16'hffff);
        push_request(CMD_NONE, 6'd63, 6'd63, 16'hffff, 16'hffff, 16'hffff);
        wait_idle();

        // shortened vector: three elements taken, then the length drops to two
        set_regs(16'd8, 16'd16, 16'd4096, 16'd256);
        repeat (3) push_element(rand_word(), rand_word());
        wait_idle();
        write_reg(REG_VEC_LEN, 16'd2);
        push_element(rand_word(), rand_word());
        wait_idle();

        // random phases: new settings, some random requests of any command, one whole vector
        while (items < 250) begin
            if (items == 0)
                len_val = 16'd127;
            else if ($urandom_range(0, 9) == 0)
                len_val = 16'($urandom) & 16'hff80 | 16'($urandom_range(0, 1) ? 0 : 96);
            else if (big_runs < 2 && $urandom_range(0, 7) == 0)
                len_val = 16'($urandom_range(9, 64));
            else
                len_val = 16'($urandom_range(1, 8));
            len = (len_val[6:0] == 0) ? 1 : (len_val[6:0] > MaxLen) ? MaxLen : len_val[6:0];
            if (len > 8)
                big_runs++;
            set_regs(len_val, 16'($urandom), pick_gain(), pick_gain());
            repeat ($urandom_range(0, 6)) begin
                push_request(t_cmd'($urandom_range(0, 3)), 6'($urandom), 6'($urandom),
                             rand_word(), rand_word(), rand_word());
                items++;
            end
            for (int e = 0; e < len; e++)
                push_element(rand_word(), rand_word());
            items += len;
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
